@@ rtl/binary_to_decimal_digits_top_defines.svh @@
// Assertion macros for the decimal digit converter checkers.
`ifndef BINARY_TO_DECIMAL_DIGITS_TOP_DEFINES_SVH
`define BINARY_TO_DECIMAL_DIGITS_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define B2D_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define B2D_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/b2d_pkg.sv @@
`timescale 1ns / 1ps

package b2d_pkg;

    localparam int NUM_BITS   = 32;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;

    typedef struct packed {
        logic [BCD_W-1:0]    bcd;
        logic [NUM_BITS-1:0] bin;
    } word_t;

endpackage

@@ rtl/b2d_cell.sv @@
`timescale 1ns / 1ps

module b2d_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    input  b2d_pkg::word_t up_data,
    output logic          take,
    input  logic          down_take,
    output logic          valid,
    output b2d_pkg::word_t data
);

    logic           valid_reg;
    logic           valid_next;
    b2d_pkg::word_t data_reg;
    b2d_pkg::word_t data_next;
    logic [b2d_pkg::BCD_W-1:0] bcd_adj;

    assign take = !valid_reg || down_take;

    // add three to every digit of five or more, then shift in the next binary bit
    always_comb
    begin
        for (int i = 0; i < b2d_pkg::NUM_DIGITS; i++)
        begin
            if (up_data.bcd[i*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W] >= 4'd5)
            begin
                bcd_adj[i*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W] =
                    up_data.bcd[i*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W] + 4'd3;
            end
            else
            begin
                bcd_adj[i*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W] =
                    up_data.bcd[i*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W];
            end
        end
        data_next.bcd = {bcd_adj[b2d_pkg::BCD_W-2:0], up_data.bin[b2d_pkg::NUM_BITS-1]};
        data_next.bin = {up_data.bin[b2d_pkg::NUM_BITS-2:0], 1'b0};
        valid_next    = take ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

@@ rtl/binary_to_decimal_digits_top.sv @@
`timescale 1ns / 1ps

// Channel   Valid          Stall          Payload
// value     value_valid    value_stall    binary_value (32 bits)
// digits    digits_valid   digits_stall   digit_billions .. digit_units
//
// One word per cycle sustained while digits_stall is low, through a row of 32 cells.
// Each cell does one shift-and-add-three step; the last cell is the output register.
// Reset clears the valid bit of every cell; payload registers are not reset.
// A stalled output holds; cells behind it keep filling into empty slots, and
// value_stall rises only once every cell holds a word.

module binary_to_decimal_digits_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        value_valid,
    output logic        value_stall,
    input  logic [31:0] binary_value,
    output logic        digits_valid,
    input  logic        digits_stall,
    output logic [2:0]  digit_billions,
    output logic [3:0]  digit_hundred_millions,
    output logic [3:0]  digit_ten_millions,
    output logic [3:0]  digit_millions,
    output logic [3:0]  digit_hundred_thousands,
    output logic [3:0]  digit_ten_thousands,
    output logic [3:0]  digit_thousands,
    output logic [3:0]  digit_hundreds,
    output logic [3:0]  digit_tens,
    output logic [3:0]  digit_units
);

    localparam int N = b2d_pkg::NUM_BITS;

    logic           stage_valid [0:N];
    logic           stage_take  [0:N];
    b2d_pkg::word_t stage_data  [0:N];
    logic [b2d_pkg::BCD_W-1:0] bcd;

    assign stage_valid[0]   = value_valid;
    assign stage_data[0].bcd = '0;
    assign stage_data[0].bin = binary_value;
    assign stage_take[N]    = !digits_stall;

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        b2d_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .up_valid  (stage_valid[g]),
            .up_data   (stage_data[g]),
            .take      (stage_take[g]),
            .down_take (stage_take[g+1]),
            .valid     (stage_valid[g+1]),
            .data      (stage_data[g+1])
        );
    end

    assign value_stall  = !stage_take[0];
    assign digits_valid = stage_valid[N];
    assign bcd          = stage_data[N].bcd;

    assign digit_billions          = bcd[38:36];
    assign digit_hundred_millions  = bcd[35:32];
    assign digit_ten_millions      = bcd[31:28];
    assign digit_millions          = bcd[27:24];
    assign digit_hundred_thousands = bcd[23:20];
    assign digit_ten_thousands     = bcd[19:16];
    assign digit_thousands         = bcd[15:12];
    assign digit_hundreds          = bcd[11:8];
    assign digit_tens              = bcd[7:4];
    assign digit_units             = bcd[3:0];

endmodule

@@ rtl/b2d_checker.sv @@
`timescale 1ns / 1ps
`include "binary_to_decimal_digits_top_defines.svh"

module b2d_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       value_stall,
    input logic       digits_valid,
    input logic       digits_stall,
    input logic [2:0] digit_billions,
    input logic [3:0] digit_hundred_millions,
    input logic [3:0] digit_millions,
    input logic [3:0] digit_thousands,
    input logic [3:0] digit_units
);

    `B2D_ASSERT_NEXT(a_out_hold, digits_valid && digits_stall, digits_valid)
    `B2D_ASSERT_NEXT(a_out_stable, digits_valid && digits_stall, $stable(digit_units) && $stable(digit_millions) && $stable(digit_billions))
    `B2D_ASSERT_NOW(a_digit_range, digits_valid, digit_billions <= 3'd4 && digit_hundred_millions <= 4'd9 && digit_thousands <= 4'd9 && digit_units <= 4'd9)
    `B2D_ASSERT_NOW(a_stall_only_when_full, value_stall, digits_valid && digits_stall)

endmodule

bind binary_to_decimal_digits_top b2d_checker u_b2d_checker
(
    .clk                    (clk),
    .rst_n                  (rst_n),
    .value_stall            (value_stall),
    .digits_valid           (digits_valid),
    .digits_stall           (digits_stall),
    .digit_billions         (digit_billions),
    .digit_hundred_millions (digit_hundred_millions),
    .digit_millions         (digit_millions),
    .digit_thousands        (digit_thousands),
    .digit_units            (digit_units)
);

@@ tb/binary_to_decimal_digits_checker.sv @@
`timescale 1ns / 1ps

module binary_to_decimal_digits_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        value_valid,
    input  logic        value_stall,
    input  logic [b2d_pkg::NUM_BITS-1:0] binary_value,
    input  logic        digits_valid,
    input  logic        digits_stall,
    input  logic [2:0]  digit_billions,
    input  logic [3:0]  digit_hundred_millions,
    input  logic [3:0]  digit_ten_millions,
    input  logic [3:0]  digit_millions,
    input  logic [3:0]  digit_hundred_thousands,
    input  logic [3:0]  digit_ten_thousands,
    input  logic [3:0]  digit_thousands,
    input  logic [3:0]  digit_hundreds,
    input  logic [3:0]  digit_tens,
    input  logic [3:0]  digit_units,
    output int          error_count,
    output int          words_in_flight
);

    localparam int unsigned PLACE_WEIGHT [b2d_pkg::NUM_DIGITS] = '{
        1000000000, 100000000, 10000000, 1000000, 100000,
        10000, 1000, 100, 10, 1
    };

    typedef struct packed {
        logic [2:0] billions;
        logic [3:0] hundred_millions;
        logic [3:0] ten_millions;
        logic [3:0] millions;
        logic [3:0] hundred_thousands;
        logic [3:0] ten_thousands;
        logic [3:0] thousands;
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] units;
    } digits_t;

    digits_t expected_digits [$];

    initial
    begin
        error_count     = 0;
        words_in_flight = 0;
    end

    function automatic digits_t decimal_digits(input logic [31:0] value);
        int unsigned rest;
        logic [3:0]  place_digit [b2d_pkg::NUM_DIGITS];
        digits_t     split;
        rest = value;
        for (int k = 0; k < b2d_pkg::NUM_DIGITS; k++)
        begin
            place_digit[k] = 4'(rest / PLACE_WEIGHT[k]);
            rest           = rest % PLACE_WEIGHT[k];
        end
        split.billions          = place_digit[0][2:0];
        split.hundred_millions  = place_digit[1];
        split.ten_millions      = place_digit[2];
        split.millions          = place_digit[3];
        split.hundred_thousands = place_digit[4];
        split.ten_thousands     = place_digit[5];
        split.thousands         = place_digit[6];
        split.hundreds          = place_digit[7];
        split.tens              = place_digit[8];
        split.units             = place_digit[9];
        return split;
    endfunction

    task automatic check_digit(input string place, input logic [3:0] want,
                               input logic [3:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s digit mismatch, expected %0d, actual %0d",
                     $time, place, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        digits_t want;
        if (rst_n)
        begin
            if (digits_valid && !digits_stall)
            begin
                if (expected_digits.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected word, expected none, actual %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                             $time, digit_billions, digit_hundred_millions,
                             digit_ten_millions, digit_millions,
                             digit_hundred_thousands, digit_ten_thousands,
                             digit_thousands, digit_hundreds, digit_tens,
                             digit_units);
                end
                else
                begin
                    want = expected_digits.pop_front();
                    check_digit("billions", {1'b0, want.billions}, {1'b0, digit_billions});
                    check_digit("hundred millions", want.hundred_millions,
                                digit_hundred_millions);
                    check_digit("ten millions", want.ten_millions, digit_ten_millions);
                    check_digit("millions", want.millions, digit_millions);
                    check_digit("hundred thousands", want.hundred_thousands,
                                digit_hundred_thousands);
                    check_digit("ten thousands", want.ten_thousands, digit_ten_thousands);
                    check_digit("thousands", want.thousands, digit_thousands);
                    check_digit("hundreds", want.hundreds, digit_hundreds);
                    check_digit("tens", want.tens, digit_tens);
                    check_digit("units", want.units, digit_units);
                end
            end
            if (value_valid && !value_stall)
                expected_digits.push_back(decimal_digits(binary_value));
            words_in_flight = expected_digits.size();
        end
    end

endmodule

@@ tb/tb_binary_to_decimal_digits_top.sv @@
`timescale 1ns / 1ps

module tb_binary_to_decimal_digits_top;

    localparam int IDLE_PERCENT   = 26;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int DRAIN_CYCLES   = 64;

    localparam logic [31:0] DIRECTED_VALUES [22] = '{
        32'd0, 32'hFFFF_FFFF, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100,
        32'd999, 32'd1000, 32'd999999, 32'd999999999, 32'd1000000000,
        32'd1999999999, 32'd3999999999, 32'd4000000000, 32'd4294967294,
        32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
        32'd1234567890, 32'd987654321
    };

    localparam int unsigned POWER_OF_TEN [10] = '{
        1, 10, 100, 1000, 10000, 100000, 1000000, 10000000, 100000000,
        1000000000
    };

    logic        clk;
    logic        rst_n;
    logic        value_valid;
    logic        value_stall;
    logic [31:0] binary_value;
    logic        digits_valid;
    logic        digits_stall;
    logic [2:0]  digit_billions;
    logic [3:0]  digit_hundred_millions;
    logic [3:0]  digit_ten_millions;
    logic [3:0]  digit_millions;
    logic [3:0]  digit_hundred_thousands;
    logic [3:0]  digit_ten_thousands;
    logic [3:0]  digit_thousands;
    logic [3:0]  digit_hundreds;
    logic [3:0]  digit_tens;
    logic [3:0]  digit_units;

    int          error_count;
    int          words_in_flight;
    int          quiet_cycles;
    logic        quiet;

    binary_to_decimal_digits_top uut
    (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .value_valid             (value_valid),
        .value_stall             (value_stall),
        .binary_value            (binary_value),
        .digits_valid            (digits_valid),
        .digits_stall            (digits_stall),
        .digit_billions          (digit_billions),
        .digit_hundred_millions  (digit_hundred_millions),
        .digit_ten_millions      (digit_ten_millions),
        .digit_millions          (digit_millions),
        .digit_hundred_thousands (digit_hundred_thousands),
        .digit_ten_thousands     (digit_ten_thousands),
        .digit_thousands         (digit_thousands),
        .digit_hundreds          (digit_hundreds),
        .digit_tens              (digit_tens),
        .digit_units             (digit_units)
    );

    binary_to_decimal_digits_checker digit_checker
    (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .value_valid             (value_valid),
        .value_stall             (value_stall),
        .binary_value            (binary_value),
        .digits_valid            (digits_valid),
        .digits_stall            (digits_stall),
        .digit_billions          (digit_billions),
        .digit_hundred_millions  (digit_hundred_millions),
        .digit_ten_millions      (digit_ten_millions),
        .digit_millions          (digit_millions),
        .digit_hundred_thousands (digit_hundred_thousands),
        .digit_ten_thousands     (digit_ten_thousands),
        .digit_thousands         (digit_thousands),
        .digit_hundreds          (digit_hundreds),
        .digit_tens              (digit_tens),
        .digit_units             (digit_units),
        .error_count             (error_count),
        .words_in_flight         (words_in_flight)
    );

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        value_valid  = 1'b0;
        binary_value = '0;
        digits_stall = 1'b0;
        quiet        = 1'b0;
        quiet_cycles = 0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (quiet)
            digits_stall <= 1'b0;
        else
            digits_stall <= ($urandom_range(99) < IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (value_valid && !value_stall) || (digits_valid && !digits_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [31:0] random_value();
        int unsigned place;
        logic [31:0] near;
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(999);
            2: return $urandom >> $urandom_range(31);
            3:
            begin
                place = POWER_OF_TEN[$urandom_range(9)];
                near  = place * $urandom_range(1, 4);
                return near + $urandom_range(2) - 1;
            end
            default: return 32'hFFFF_FFFF - $urandom_range(300000000);
        endcase
    endfunction

    // hold the word until the edge that takes it; return just before that edge
    task automatic send_value(input logic [31:0] value);
        if (!quiet)
        begin
            while ($urandom_range(99) < IDLE_PERCENT)
            begin
                @(posedge clk);
                value_valid <= 1'b0;
                @(negedge clk);
            end
        end
        @(posedge clk);
        value_valid  <= 1'b1;
        binary_value <= value;
        @(negedge clk);
        while (value_stall)
            @(negedge clk);
    endtask

    task automatic drain_words();
        @(posedge clk);
        value_valid <= 1'b0;
        @(negedge clk);
        while (words_in_flight != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_VALUES[i])
            send_value(DIRECTED_VALUES[i]);

        repeat (600)
            send_value(random_value());

        drain_words();

        quiet = 1'b1;
        repeat (400)
            send_value(random_value());
        quiet = 1'b0;

        repeat (880)
            send_value(random_value());

        drain_words();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && words_in_flight == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/b2d_pkg.sv
rtl/b2d_cell.sv
rtl/binary_to_decimal_digits_top.sv
rtl/b2d_checker.sv
tb/binary_to_decimal_digits_checker.sv
tb/tb_binary_to_decimal_digits_top.sv
